### hw/rtl/rmts_pkg.sv
// Shared types and constants for the rate monotonic tick scheduler.
// Used by the task cell, the top level and the port checker.
`default_nettype none

package rmts_pkg;

  localparam int unsigned IdW     = 4;
  localparam int unsigned WcetW   = 10;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned BudgetW = 16;

  localparam logic [BudgetW-1:0] BudgetMax = {BudgetW{1'b1}};

  // Command codes of an input request.
  localparam logic CmdLoad = 1'b0;
  localparam logic CmdTick = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Candidate handed from cell to cell during a scan.
  typedef struct packed {
    logic               found;
    logic [PeriodW:0]   best;         // effective period of the current winner
    logic [IdW-1:0]     idx;
    logic               sat_others;   // saturation seen in cells that did not win
    logic               sat_best_np;  // winner's saturation if it ends up not picked
    logic               sat_best_p;   // winner's saturation if it ends up picked
  } cand_t;

  // Load data for one slot.
  typedef struct packed {
    logic [WcetW-1:0]   wcet;
    logic [PeriodW-1:0] period;
  } load_t;

  // Tick update broadcast to every cell.
  typedef struct packed {
    logic               apply;
    logic               found;
    logic [IdW-1:0]     idx;
    logic               first;
  } upd_t;

endpackage

`default_nettype wire

### hw/rtl/rate_monotonic_tick_scheduler_core.sv
// Top level of the rate monotonic tick scheduler: request handshakes, the scan
// sequencer and the chain of task cells. Depends on rmts_pkg and rmts_cell.
//
// Usage: the input channel (in_valid/in_ready) carries requests of two kinds.
// A load request (cmd = 0) writes one task slot (wcet, period); it produces no
// result. A load to a slot at or above MAX_TASKS is dropped.
// A tick request (cmd = 1) produces one result on the output channel
// (out_valid/out_ready): the slot that ran, an idle flag and a saturation flag.
// A tick's candidate travels one cell per cycle down the chain of MAX_TASKS
// cells during the scan state, then the done state applies the update and
// loads the output register. A new tick is accepted only after the last one
// has left the done state.
// in_ready is high only while the sequencer is idle. A result waits in the
// output register; the sequencer may accept and scan the next tick meanwhile,
// and holds that tick's update until the output register is free.
// Reset (rst, synchronous) clears every slot's valid bit, sets the first tick
// mark and empties the output register. The first tick after reset refills
// no budget.
`default_nettype none

module rate_monotonic_tick_scheduler_core #(
  parameter int unsigned MAX_TASKS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         cmd,
  input  wire logic [rmts_pkg::IdW-1:0]     task_id,
  input  wire logic [rmts_pkg::WcetW-1:0]   wcet,
  input  wire logic [rmts_pkg::PeriodW-1:0] period,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [rmts_pkg::IdW-1:0]          running_task,
  output logic                              idle,
  output logic                              budget_saturated
);

  localparam int unsigned CntW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  rmts_pkg::state_t state;
  rmts_pkg::state_t state_next;
  logic [CntW-1:0]  cnt;
  logic [CntW-1:0]  cnt_next;
  logic             first_pending;

  logic             in_fire;
  logic             ld_fire;
  logic             tick_fire;
  logic             finish;
  logic [MAX_TASKS-1:0] load_en;

  rmts_pkg::load_t  ld;
  rmts_pkg::upd_t   upd;
  rmts_pkg::cand_t  chain [MAX_TASKS+1];
  rmts_pkg::cand_t  final_cand;

  assign in_ready  = (state == rmts_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign ld_fire   = in_fire && (cmd == rmts_pkg::CmdLoad);
  assign tick_fire = in_fire && (cmd == rmts_pkg::CmdTick);

  // Sequencer: next state and the update strobe.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    finish     = 1'b0;
    case (state)
      rmts_pkg::ST_IDLE: begin
        if (tick_fire) begin
          state_next = rmts_pkg::ST_SCAN;
          cnt_next   = '0;
        end
      end
      rmts_pkg::ST_SCAN: begin
        cnt_next = cnt + 1'b1;
        if (cnt == CntW'(MAX_TASKS - 1)) begin
          state_next = rmts_pkg::ST_DONE;
        end
      end
      rmts_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          finish     = 1'b1;
          state_next = rmts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rmts_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= rmts_pkg::ST_IDLE;
      cnt           <= '0;
      first_pending <= 1'b1;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (finish) begin
        first_pending <= 1'b0;
      end
    end
  end

  // Broadcasts to the cells.
  assign ld.wcet    = wcet;
  assign ld.period  = period;
  assign final_cand = chain[MAX_TASKS];
  assign upd.apply  = finish;
  assign upd.found  = final_cand.found;
  assign upd.idx    = final_cand.idx;
  assign upd.first  = first_pending;

  // Chain head enters with no candidate.
  assign chain[0] = '0;

  for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
    assign load_en[k] = ld_fire && ({{(32-rmts_pkg::IdW){1'b0}}, task_id} == 32'(k));

    rmts_cell #(
      .CELL_ID (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .load_en  (load_en[k]),
      .ld       (ld),
      .upd      (upd),
      .cand_in  (chain[k]),
      .cand_out (chain[k+1])
    );
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (finish) begin
      running_task     <= final_cand.found ? final_cand.idx : '0;
      idle             <= !final_cand.found;
      budget_saturated <= final_cand.sat_others ||
                          (final_cand.found && final_cand.sat_best_p);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rmts_cell.sv
// One task slot of the scheduler chain: holds the slot state, folds itself into
// the passing candidate and applies the tick update. Depends on rmts_pkg.
`default_nettype none

module rmts_cell #(
  parameter int unsigned CELL_ID = 0
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           load_en,
  input  wire rmts_pkg::load_t ld,
  input  wire rmts_pkg::upd_t upd,
  input  wire rmts_pkg::cand_t cand_in,
  output rmts_pkg::cand_t     cand_out
);

  logic                          valid;
  logic [rmts_pkg::WcetW-1:0]    full;
  logic [rmts_pkg::PeriodW-1:0]  per;
  logic [rmts_pkg::BudgetW-1:0]  budget;
  logic [rmts_pkg::PeriodW-1:0]  phase;

  logic [rmts_pkg::PeriodW-1:0]  phase_inc;
  logic                          hit;
  logic                          refill;
  logic                          elig;
  logic [rmts_pkg::PeriodW:0]    eff;
  logic [rmts_pkg::BudgetW-1:0]  dec;
  logic [rmts_pkg::BudgetW:0]    sum_np;
  logic [rmts_pkg::BudgetW:0]    sum_p;
  logic                          sat_np;
  logic                          sat_p;
  logic                          win;
  logic                          picked;
  logic [rmts_pkg::BudgetW:0]    sum_sel;
  logic [rmts_pkg::BudgetW-1:0]  budget_sel;
  logic [rmts_pkg::IdW-1:0]      my_id;
  rmts_pkg::cand_t               cand_next;

  assign my_id = rmts_pkg::IdW'(CELL_ID);

  // Slot view for this tick: phase wrap, refill and both saturation outcomes.
  always_comb begin
    phase_inc = phase + 1'b1;
    hit       = (phase_inc == per);
    refill    = valid && hit && !upd.first;
    elig      = valid && (budget != '0);
    eff       = {(per == '0), per};
    dec       = budget - 1'b1;
    sum_np    = {1'b0, budget} + (rmts_pkg::BudgetW+1)'(full);
    sum_p     = {1'b0, dec} + (rmts_pkg::BudgetW+1)'(full);
    sat_np    = refill && sum_np[rmts_pkg::BudgetW];
    sat_p     = refill && sum_p[rmts_pkg::BudgetW];
    win       = elig && (!cand_in.found || (eff < cand_in.best));
  end

  // Fold this slot into the candidate; a strict compare keeps lower slots on ties.
  always_comb begin
    cand_next = cand_in;
    if (win) begin
      cand_next.found       = 1'b1;
      cand_next.best        = eff;
      cand_next.idx         = my_id;
      cand_next.sat_others  = cand_in.sat_others || (cand_in.found && cand_in.sat_best_np);
      cand_next.sat_best_np = sat_np;
      cand_next.sat_best_p  = sat_p;
    end else begin
      cand_next.sat_others  = cand_in.sat_others || sat_np;
    end
  end

  always_ff @(posedge clk) begin
    cand_out <= cand_next;
  end

  // Budget after the tick: spend one unit if picked, then refill with clipping.
  always_comb begin
    picked     = valid && upd.found && (upd.idx == my_id);
    sum_sel    = picked ? sum_p : sum_np;
    budget_sel = picked ? dec : budget;
  end

  // Control state of the slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load_en) begin
      valid <= 1'b1;
    end
  end

  // Slot payload: written by a load, advanced by a tick update.
  always_ff @(posedge clk) begin
    if (load_en) begin
      full   <= ld.wcet;
      per    <= ld.period;
      budget <= rmts_pkg::BudgetW'(ld.wcet);
      phase  <= '0;
    end else if (upd.apply && valid) begin
      phase <= hit ? '0 : phase_inc;
      if (refill) begin
        budget <= sum_sel[rmts_pkg::BudgetW] ? rmts_pkg::BudgetMax
                                             : sum_sel[rmts_pkg::BudgetW-1:0];
      end else begin
        budget <= budget_sel;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rmts_checker.sv
// Port-level checks for the rate monotonic tick scheduler, bound to the top level.
// Depends on rate_monotonic_tick_scheduler_core and rmts_pkg.
`default_nettype none

module rmts_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [rmts_pkg::IdW-1:0]     running_task,
  input wire logic                         idle,
  input wire logic                         budget_saturated
);

  // A stalled result stays on offer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // An idle tick reports slot zero.
  a_idle_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && idle |-> running_task == '0)
    else $error("idle result with nonzero slot");

  // Saturation needs a task holding budget, so an idle tick cannot saturate.
  a_idle_nosat: assert property (@(posedge clk) disable iff (rst)
    out_valid && idle |-> !budget_saturated)
    else $error("idle result with saturation flag");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind rate_monotonic_tick_scheduler_core rmts_checker u_rmts_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .running_task     (running_task),
  .idle             (idle),
  .budget_saturated (budget_saturated)
);

`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for rate_monotonic_tick_scheduler_core.
// It needs rmts_pkg and the core RTL. A task-table predictor inside a small
// scoreboard class checks every tick result against the expected schedule.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_TASKS  = 16;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned MaxReports = 10;

  // Schedule decision for one tick, as seen on the result channel.
  typedef struct packed {
    logic [rmts_pkg::IdW-1:0] ran_slot;
    logic                     no_task;
    logic                     clipped;
  } tick_result_t;

  // Keeps a copy of the task table, predicts each tick's decision and
  // checks results in order against those predictions.
  class tick_ledger;
    bit                           slot_live   [MAX_TASKS];
    logic [rmts_pkg::WcetW-1:0]   slot_wcet   [MAX_TASKS];
    logic [rmts_pkg::PeriodW-1:0] slot_period [MAX_TASKS];
    logic [rmts_pkg::BudgetW-1:0] slot_budget [MAX_TASKS];
    logic [rmts_pkg::PeriodW-1:0] slot_phase  [MAX_TASKS];
    bit                           first_tick;
    tick_result_t                 due_ticks[$];
    int unsigned                  loads, ticks, idles, saturations, errors;

    function new();
      foreach (slot_live[k]) slot_live[k] = 1'b0;
      first_tick = 1'b1;
    endfunction

    // Pick the live task with the shortest period, spend one unit, then refill.
    function tick_result_t run_tick();
      tick_result_t               res;
      logic [rmts_pkg::PeriodW:0] eff;
      logic [rmts_pkg::PeriodW:0] best;
      logic [rmts_pkg::BudgetW:0] sum;
      int                         pick;
      int                         k;
      pick = -1;
      best = '0;
      res  = '0;
      for (k = 0; k < MAX_TASKS; k++) begin
        if (slot_live[k] && slot_budget[k] != '0) begin
          // A zero period stands for the longest possible period.
          eff = (slot_period[k] == '0) ? {1'b1, {rmts_pkg::PeriodW{1'b0}}}
                                       : {1'b0, slot_period[k]};
          if (pick < 0 || eff < best) begin
            pick = k;
            best = eff;
          end
        end
      end
      if (pick >= 0) slot_budget[pick] = slot_budget[pick] - 1'b1;

      // Phase counters wrap at 16 bits; the first tick after reset adds nothing.
      for (k = 0; k < MAX_TASKS; k++) begin
        if (slot_live[k]) begin
          slot_phase[k] = slot_phase[k] + 1'b1;
          if (slot_phase[k] == slot_period[k]) begin
            slot_phase[k] = '0;
            if (!first_tick) begin
              sum = {1'b0, slot_budget[k]} + slot_wcet[k];
              if (sum > {1'b0, rmts_pkg::BudgetMax}) begin
                sum = {1'b0, rmts_pkg::BudgetMax};
                res.clipped = 1'b1;
              end
              slot_budget[k] = sum[rmts_pkg::BudgetW-1:0];
            end
          end
        end
      end
      first_tick = 1'b0;

      res.ran_slot = (pick >= 0) ? rmts_pkg::IdW'(pick) : '0;
      res.no_task  = (pick < 0);
      return res;
    endfunction

    function void note_request(logic c, logic [rmts_pkg::IdW-1:0] id,
                               logic [rmts_pkg::WcetW-1:0] w,
                               logic [rmts_pkg::PeriodW-1:0] p);
      tick_result_t res;
      if (c == rmts_pkg::CmdTick) begin
        res = run_tick();
        ticks++;
        if (res.no_task) idles++;
        if (res.clipped) saturations++;
        due_ticks.insert(due_ticks.size(), res);
      end else begin
        loads++;
        if (id < MAX_TASKS) begin
          slot_live[id]   = 1'b1;
          slot_wcet[id]   = w;
          slot_period[id] = p;
          slot_budget[id] = rmts_pkg::BudgetW'(w);
          slot_phase[id]  = '0;
        end
      end
    endfunction

    function void check_tick(logic [rmts_pkg::IdW-1:0] ran, logic no_task, logic clipped);
      tick_result_t want;
      if (due_ticks.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("Unexpected result: task %0d idle %0b sat %0b", ran, no_task, clipped);
        return;
      end
      want = due_ticks.pop_front();
      if (ran !== want.ran_slot || no_task !== want.no_task || clipped !== want.clipped) begin
        errors++;
        if (errors <= MaxReports)
          $display("Mismatch: expected task %0d idle %0b sat %0b, got task %0d idle %0b sat %0b",
                   want.ran_slot, want.no_task, want.clipped, ran, no_task, clipped);
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           cmd = rmts_pkg::CmdLoad;
  logic [rmts_pkg::IdW-1:0]       task_id = '0;
  logic [rmts_pkg::WcetW-1:0]     wcet = '0;
  logic [rmts_pkg::PeriodW-1:0]   period = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [rmts_pkg::IdW-1:0]       running_task;
  logic                           idle;
  logic                           budget_saturated;

  tick_ledger  ledger;
  int unsigned sent_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_len = 0;
  int unsigned stall_run = 0;
  int unsigned longest_stall = 0;

  rate_monotonic_tick_scheduler_core #(.MAX_TASKS(MAX_TASKS)) DUT (
    .clk, .rst, .in_valid, .in_ready, .cmd, .task_id, .wcet, .period,
    .out_valid, .out_ready, .running_task, .idle, .budget_saturated
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("Timeout after %0d cycles", CycleLimit);
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_ready <= 1'b0;
        hold_len--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Input monitor: feeds accepted requests to the predictor.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) ledger.note_request(cmd, task_id, wcet, period);
    if (!rst && in_valid && !in_ready) begin
      stall_run++;
      if (stall_run > longest_stall) longest_stall = stall_run;
    end else begin
      stall_run = 0;
    end
  end

  // Output monitor: checks each accepted result.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) ledger.check_tick(running_task, idle, budget_saturated);
  end

  // Offer one request, with random idle cycles first, and wait for acceptance.
  task automatic send_request(input logic c, input logic [rmts_pkg::IdW-1:0] id,
                              input logic [rmts_pkg::WcetW-1:0] w,
                              input logic [rmts_pkg::PeriodW-1:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    task_id  <= id;
    wcet     <= w;
    period   <= p;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  task automatic send_load(input logic [rmts_pkg::IdW-1:0] id,
                           input logic [rmts_pkg::WcetW-1:0] w,
                           input logic [rmts_pkg::PeriodW-1:0] p);
    send_request(rmts_pkg::CmdLoad, id, w, p);
  endtask

  // Tick payload fields are unused, so they carry random bits.
  task automatic send_tick();
    send_request(rmts_pkg::CmdTick, rmts_pkg::IdW'($urandom), rmts_pkg::WcetW'($urandom),
                 rmts_pkg::PeriodW'($urandom));
  endtask

  // One random sequence: mostly loads followed by a burst of ticks.
  task automatic random_scenario();
    int unsigned                  pick;
    int unsigned                  n;
    logic [rmts_pkg::IdW-1:0]     slot;
    logic [rmts_pkg::WcetW-1:0]   w;
    logic [rmts_pkg::PeriodW-1:0] p;
    pick = $urandom_range(99);
    if (pick < 10) begin
      // Drive one task's budget into the ceiling, then retire it.
      slot = rmts_pkg::IdW'($urandom_range(MAX_TASKS - 1));
      send_load(slot, rmts_pkg::WcetW'($urandom_range(1023, 950)), rmts_pkg::PeriodW'(1));
      repeat ($urandom_range(90, 75)) send_tick();
      send_load(slot, '0, rmts_pkg::PeriodW'($urandom));
    end else if (pick < 85) begin
      n = $urandom_range(4, 1);
      repeat (n) begin
        slot = rmts_pkg::IdW'($urandom_range(MAX_TASKS - 1));
        w = ($urandom_range(99) < 20) ? rmts_pkg::WcetW'($urandom)
                                      : rmts_pkg::WcetW'($urandom_range(12));
        n = $urandom_range(99);
        if (n < 15)      p = rmts_pkg::PeriodW'($urandom);
        else if (n < 20) p = '0;
        else             p = rmts_pkg::PeriodW'($urandom_range(24, 1));
        send_load(slot, w, p);
      end
      repeat ($urandom_range(40, 4)) send_tick();
    end else begin
      // Noise: loads with any field values mixed with ticks.
      repeat ($urandom_range(6, 1)) begin
        if ($urandom_range(1))
          send_load(rmts_pkg::IdW'($urandom), rmts_pkg::WcetW'($urandom),
                    rmts_pkg::PeriodW'($urandom));
        else
          send_tick();
      end
    end
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall,
                           input int unsigned goal);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    while (sent_count < goal) random_scenario();
  endtask

  initial begin
    ledger = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, extreme fields, ties, zero budget, zero period, reload.
    send_tick();
    send_load(4'd15, 10'd1023, 16'hFFFF);
    send_load(4'd0, 10'd1, 16'd1);
    send_load(4'd3, 10'd2, 16'd1);
    send_load(4'd7, 10'd0, 16'd5);
    send_load(4'd9, 10'd3, 16'd0);
    send_load(4'd12, 10'd512, 16'h8000);
    repeat (6) send_tick();
    send_load(4'd0, 10'd5, 16'd2);
    repeat (6) send_tick();

    // No idling, with one long receiver hold-off so the core backs up.
    hold_len = 400;
    run_phase(0, 0, 420);
    run_phase(62, 0, 800);
    run_phase(0, 62, 1180);
    run_phase(8, 8, 1550);
    in_valid <= 1'b0;

    while (ledger.due_ticks.size() != 0) @(posedge clk);
    repeat (2 * MAX_TASKS + 8) @(posedge clk);
    if (ledger.due_ticks.size() != 0) ledger.errors++;

    $display("Run covered %0d loads and %0d ticks: %0d idle, %0d with budget clipped.",
             ledger.loads, ledger.ticks, ledger.idles, ledger.saturations);
    $display("Longest input stall %0d cycles; %0d mismatching results.",
             longest_stall, ledger.errors);
    if (ledger.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
